// ----- src/pvm_pkg.sv -----
// ----------------------------------------------------------------------------
// pvm_pkg
// Shared types and constants of the sample voice mixer.
// ----------------------------------------------------------------------------
package pvm_pkg;

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_PAUSE = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_VOICE = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    E_IDLE,
    E_EXEC,
    E_VCHK,
    E_MOD,
    E_BASE,
    E_RED,
    E_RD1,
    E_RD2,
    E_MUL,
    E_ACC,
    E_SC1,
    E_SC2,
    E_SC3,
    E_SC4
  } eng_state_t;

  typedef struct packed {
    cmd_e               op;
    logic [15:0]        addr;
    logic signed [15:0] value;
    logic [15:0]        start;
    logic [15:0]        len;
    logic [23:0]        step;
    logic [7:0]         sid;
    logic [15:0]        key;
    logic               instr;
    logic               loop;
  } cmd_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               chan;
    logic               audio;
    status_e            status;
    logic               last;
  } res_t;

  // queue depth on both sides of the engine
  localparam int QDEPTH = 4;
  // width of a frame word index before wrapping: (start + index) * channels
  localparam int FW = 18;
  // channel accumulator width, room for 64 full scale voices
  localparam int ACCW = 40;
  // accumulator lanes in hardware
  localparam int NCH_HW = 2;

endpackage

// ----- src/pvm_front.sv -----
// ----------------------------------------------------------------------------
// pvm_front
// Command intake: takes words, drops unused codes, queues decoded commands.
// ----------------------------------------------------------------------------
module pvm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          cmd,
  input  logic [15:0]         sample_addr,
  input  logic signed [15:0]  sample_value,
  input  logic [15:0]         start_frame,
  input  logic [15:0]         length_frames,
  input  logic [23:0]         step_ratio,
  input  logic [7:0]          sound_id,
  input  logic [15:0]         pitch_key,
  input  logic                is_instrument,
  input  logic                loop_enable,
  output logic                avail,
  input  logic                pop,
  output pvm_pkg::cmd_item_t  head
);
  import pvm_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_item_t       q [QDEPTH];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   rp;
  logic [PW:0]     cnt;
  logic            keep;
  logic            take;
  cmd_item_t       item;

  assign full  = (cnt == (PW+1)'(QDEPTH));
  assign avail = (cnt != '0);
  assign head  = q[rp];
  // unused codes are taken and dropped here
  assign keep  = push && !full && (cmd <= CMD_TICK);
  assign take  = pop && avail;

  always_comb begin
    item.op    = cmd_e'(cmd);
    item.addr  = sample_addr;
    item.value = sample_value;
    item.start = start_frame;
    item.len   = length_frames;
    item.step  = step_ratio;
    item.sid   = sound_id;
    item.key   = pitch_key;
    item.instr = is_instrument;
    item.loop  = loop_enable;
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      q[wp] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (keep) begin
        wp <= wp + 1'b1;
      end
      if (take) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (PW+1)'(keep) - (PW+1)'(take);
    end
  end

endmodule

// ----- src/pvm_outq.sv -----
// ----------------------------------------------------------------------------
// pvm_outq
// Result queue between the engine and the output port.
// ----------------------------------------------------------------------------
module pvm_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  pvm_pkg::res_t  wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output pvm_pkg::res_t  head
);
  import pvm_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  res_t          q [QDEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   cnt;
  logic          put;
  logic          take;

  assign full  = (cnt == (PW+1)'(QDEPTH));
  assign empty = (cnt == '0);
  assign head  = q[rp];
  assign put   = wr && !full;
  assign take  = pop && !empty;

  always_ff @(posedge clk) begin
    if (put) begin
      q[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (put) begin
        wp <= wp + 1'b1;
      end
      if (take) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (PW+1)'(put) - (PW+1)'(take);
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (PW+1)'(QDEPTH))
    else $error("result queue count beyond depth");
`endif

endmodule

// ----- src/pvm_rem.sv -----
// ----------------------------------------------------------------------------
// pvm_rem
// Restoring remainder unit, 16-bit by 16-bit, one bit per cycle.
// ----------------------------------------------------------------------------
module pvm_rem (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] rem
);
  logic [4:0]  cnt;
  logic [15:0] q;
  logic [15:0] r;
  logic [15:0] d;
  logic [16:0] t;
  logic [15:0] r_next;

  assign rem = r;

  always_comb begin
    t = {r, q[15]};
    if (t >= {1'b0, d}) begin
      r_next = 16'(t - {1'b0, d});
    end else begin
      r_next = t[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (cnt != '0) begin
      q <= {q[14:0], 1'b0};
      r <= r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 5'd16;
      end else if (cnt != '0) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTH
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    done && (d != '0) |-> r < d)
    else $error("remainder not below divisor");
`endif

endmodule

// ----- src/pvm_engine.sv -----
// ----------------------------------------------------------------------------
// pvm_engine
// Back end: voice table, sample memory and the tick mixing sequencer.
// ----------------------------------------------------------------------------
module pvm_engine #(
  parameter int MAX_VOICES   = 16,
  parameter int SAMPLE_WORDS = 65536,
  parameter int MAX_CHANNELS = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_avail,
  output logic                cmd_pop,
  input  pvm_pkg::cmd_item_t  cmd_head,
  input  logic [1:0]          num_channels,
  input  logic [15:0]         master_gain,
  output logic                res_push,
  input  logic                res_full,
  output pvm_pkg::res_t       res
);
  import pvm_pkg::*;

  localparam int VIW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int VCW = $clog2(MAX_VOICES + 1);
  localparam int MW  = $clog2(SAMPLE_WORDS);
  localparam int RK  = (FW >= MW) ? FW - MW : 0;
  localparam logic [39:0] NWIDE = 40'(SAMPLE_WORDS);
  localparam logic [MW:0] NW    = (MW+1)'(SAMPLE_WORDS);

  eng_state_t state;
  eng_state_t state_next;

  // voice table
  logic        v_act   [MAX_VOICES];
  logic        v_pau   [MAX_VOICES];
  logic [31:0] v_pos   [MAX_VOICES];
  logic [15:0] v_start [MAX_VOICES];
  logic [15:0] v_len   [MAX_VOICES];
  logic [23:0] v_step  [MAX_VOICES];
  logic [7:0]  v_sid   [MAX_VOICES];
  logic [15:0] v_key   [MAX_VOICES];
  logic        v_instr [MAX_VOICES];
  logic        v_loop  [MAX_VOICES];

  logic signed [15:0] mem [SAMPLE_WORDS];
  logic signed [15:0] rdata;
  logic [MW-1:0]      raddr;
  logic [MW-1:0]      waddr;
  logic               mem_we;

  cmd_item_t               cur;
  logic [VCW-1:0]          vcnt;
  logic [VIW-1:0]          vi;
  logic                    vdone;
  logic [31:0]             wpos;
  logic                    c;
  logic [FW-1:0]           x;
  logic [4:0]              kcnt;
  logic signed [15:0]      s1;
  logic signed [33:0]      prod;
  logic signed [ACCW-1:0]  acc [NCH_HW];
  logic signed [36:0]      ph;
  logic [35:0]             pl;
  logic signed [57:0]      p;

  logic [1:0]              nch;
  logic                    last_ch;
  logic [31:0]             addr32;
  logic                    addr_ok;
  logic                    free_found;
  logic [VIW-1:0]          free_idx;
  logic [15:0]             lim;
  logic                    v_skip;
  logic                    v_short;
  logic                    v_end;
  logic                    rem_start;
  logic                    rem_done;
  logic [15:0]             rem_val;
  logic [16:0]             f1;
  logic [39:0]             nsh;
  logic [1:0]              off;
  logic [MW:0]             asum;
  logic signed [ACCW-1:0]  term;
  logic signed [57:0]      pb;
  logic signed [57:0]      sh;
  logic signed [15:0]      sat;

  assign vi    = vcnt[VIW-1:0];
  assign vdone = (vcnt == VCW'(MAX_VOICES));

  always_comb begin
    if (num_channels == 2'd0) begin
      nch = 2'd1;
    end else if (num_channels > 2'(MAX_CHANNELS)) begin
      nch = 2'(MAX_CHANNELS);
    end else begin
      nch = num_channels;
    end
  end

  assign last_ch = (({1'b0, c} + 2'd1) == nch);
  assign addr32  = 32'(cur.addr);
  assign addr_ok = addr32 < 32'(SAMPLE_WORDS);
  assign waddr   = addr32[MW-1:0];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_VOICES - 1; i >= 0; i--) begin
      if (!v_act[i]) begin
        free_found = 1'b1;
        free_idx   = VIW'(i);
      end
    end
  end

  // per voice classification at the head of a voice slot
  assign lim     = v_len[vi] - 16'd1;
  assign v_skip  = !v_act[vi] || v_pau[vi];
  assign v_short = v_len[vi] < 16'd2;
  assign v_end   = v_pos[vi][31:16] >= lim;

  assign f1  = 17'(cur.start) + 17'(v_start[vi]) - 17'(cur.start) + 17'(wpos[31:16]);
  assign nsh = NWIDE << kcnt;

  // frame word address, wrapped once: the base is already reduced
  always_comb begin
    if (state == E_RD1) begin
      off = {1'b0, c};
    end else begin
      off = nch + {1'b0, c};
    end
    asum = (MW+1)'(x) + (MW+1)'(off);
    if (asum >= NW) begin
      asum = asum - NW;
    end
    raddr = asum[MW-1:0];
  end

  assign term = (ACCW'(s1) <<< 16) + ACCW'(prod);

  // scale: truncate toward zero, then saturate
  always_comb begin
    pb = p + (p[57] ? 58'(32'hFFFF_FFFF) : 58'd0);
    sh = pb >>> 32;
    if (sh > 58'sd32767) begin
      sat = 16'sd32767;
    end else if (sh < -58'sd32768) begin
      sat = -16'sd32768;
    end else begin
      sat = sh[15:0];
    end
  end

  pvm_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (v_pos[vi][31:16]),
    .divisor  (lim),
    .done     (rem_done),
    .rem      (rem_val)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= cur.value;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    mem_we     = 1'b0;
    rem_start  = 1'b0;
    res        = '0;
    res.status = ST_OK;
    res.last   = 1'b1;
    unique case (state)
      E_IDLE: begin
        if (cmd_avail) begin
          cmd_pop    = 1'b1;
          state_next = E_EXEC;
        end
      end
      E_EXEC: begin
        if (cur.op == CMD_TICK) begin
          state_next = E_VCHK;
        end else if (!res_full) begin
          res_push   = 1'b1;
          mem_we     = (cur.op == CMD_WRITE) && addr_ok;
          state_next = E_IDLE;
          if (cur.op == CMD_WRITE && !addr_ok) begin
            res.status = ST_BAD_ADDR;
          end else if (cur.op == CMD_START && !free_found) begin
            res.status = ST_NO_VOICE;
          end
        end
      end
      E_VCHK: begin
        if (vdone) begin
          state_next = E_SC1;
        end else if (!v_skip && !v_short) begin
          if (!v_end) begin
            state_next = E_BASE;
          end else if (v_loop[vi]) begin
            rem_start  = 1'b1;
            state_next = E_MOD;
          end
        end
      end
      E_MOD: begin
        if (rem_done) begin
          state_next = E_BASE;
        end
      end
      E_BASE: state_next = E_RED;
      E_RED: begin
        if (kcnt == 5'd0) begin
          state_next = E_RD1;
        end
      end
      E_RD1: state_next = E_RD2;
      E_RD2: state_next = E_MUL;
      E_MUL: state_next = E_ACC;
      E_ACC: begin
        state_next = last_ch ? E_VCHK : E_RD1;
      end
      E_SC1: state_next = E_SC2;
      E_SC2: state_next = E_SC3;
      E_SC3: state_next = E_SC4;
      E_SC4: begin
        if (!res_full) begin
          res_push   = 1'b1;
          res.sample = sat;
          res.chan   = c;
          res.audio  = 1'b1;
          res.last   = last_ch;
          state_next = last_ch ? E_IDLE : E_SC1;
        end
      end
      default: state_next = E_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      E_IDLE: begin
        if (cmd_avail) begin
          cur <= cmd_head;
        end
      end
      E_EXEC: begin
        vcnt <= '0;
        c    <= 1'b0;
        for (int i = 0; i < NCH_HW; i++) begin
          acc[i] <= '0;
        end
      end
      E_VCHK: begin
        wpos <= v_pos[vi];
        if (v_skip || v_short || !v_end || !v_loop[vi]) begin
          if (v_skip || v_short || v_end) begin
            vcnt <= vcnt + 1'b1;
          end
        end
        c <= 1'b0;
      end
      E_MOD: begin
        if (rem_done) begin
          wpos[31:16] <= rem_val;
        end
      end
      E_BASE: begin
        x    <= (nch == 2'd2) ? {f1, 1'b0} : {1'b0, f1};
        kcnt <= 5'(RK);
      end
      E_RED: begin
        if ({{(40-FW){1'b0}}, x} >= nsh) begin
          x <= x - nsh[FW-1:0];
        end
        if (kcnt != 5'd0) begin
          kcnt <= kcnt - 5'd1;
        end
      end
      E_RD1: begin
      end
      E_RD2: begin
        s1 <= rdata;
      end
      E_MUL: begin
        prod <= $signed({1'b0, wpos[15:0]}) *
                ($signed({rdata[15], rdata}) - $signed({s1[15], s1}));
      end
      E_ACC: begin
        acc[c] <= acc[c] + term;
        if (last_ch) begin
          vcnt <= vcnt + 1'b1;
        end else begin
          c <= 1'b1;
        end
      end
      E_SC1: begin
        ph <= $signed(acc[c][ACCW-1:20]) * $signed({1'b0, master_gain});
      end
      E_SC2: begin
        pl <= acc[c][19:0] * master_gain;
      end
      E_SC3: begin
        p <= ($signed(58'(ph)) <<< 20) + $signed({22'd0, pl});
      end
      E_SC4: begin
        if (!res_full && !last_ch) begin
          c <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // voice table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_VOICES; i++) begin
        v_act[i] <= 1'b0;
        v_pau[i] <= 1'b0;
      end
    end else begin
      if (state == E_EXEC && !res_full) begin
        if (cur.op == CMD_START && free_found) begin
          v_act[free_idx]   <= 1'b1;
          v_pau[free_idx]   <= 1'b0;
          v_pos[free_idx]   <= '0;
          v_start[free_idx] <= cur.start;
          v_len[free_idx]   <= cur.len;
          v_step[free_idx]  <= cur.step;
          v_sid[free_idx]   <= cur.sid;
          v_key[free_idx]   <= cur.key;
          v_instr[free_idx] <= cur.instr;
          v_loop[free_idx]  <= cur.loop;
        end
        for (int i = 0; i < MAX_VOICES; i++) begin
          if (v_act[i] && v_sid[i] == cur.sid) begin
            if (cur.op == CMD_STOP) begin
              if (cur.instr ? (v_instr[i] && v_key[i] == cur.key) : !v_instr[i]) begin
                v_act[i] <= 1'b0;
              end
            end else if (cur.op == CMD_PAUSE && !v_instr[i]) begin
              v_pau[i] <= !v_pau[i];
            end
          end
        end
      end
      // drop unpaused short voices and ended one-shots
      if (state == E_VCHK && !vdone && !v_skip && (v_short || (v_end && !v_loop[vi]))) begin
        v_act[vi] <= 1'b0;
      end
      if (state == E_ACC && last_ch) begin
        v_pos[vi] <= wpos + 32'(v_step[vi]);
      end
    end
  end

`ifndef SYNTH
  a_base_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == E_RD1) |-> ({{(40-FW){1'b0}}, x} < NWIDE))
    else $error("frame base not reduced below memory size");
  a_acc_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == E_ACC) |-> $past(state) == E_MUL)
    else $error("accumulate without product");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");
`endif

endmodule

// ----- src/polyphonic_sample_voice_mixer.sv -----
// ----------------------------------------------------------------------------
// polyphonic_sample_voice_mixer
// Wavetable voice mixer with linear interpolation. Commands enter a queue
// and results leave through another. Write, start, stop and pause each
// give one status word. After fetch and setup, a tick walks the voice
// table one slot at a time, passing over idle or paused slots; a looping
// voice that wraps takes its remainder from a bit-serial divider, and the
// single sample memory read port reads the two samples of each channel one
// after the other. After the walk, scaling handles one channel at a time.
// The memory has no clearing pass; reading words never written gives
// unspecified audio.
// ----------------------------------------------------------------------------
module polyphonic_sample_voice_mixer #(
  parameter int MAX_VOICES   = 16,
  parameter int SAMPLE_WORDS = 65536,
  parameter int MAX_CHANNELS = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         cmd,
  input  logic [15:0]        sample_addr,
  input  logic signed [15:0] sample_value,
  input  logic [15:0]        start_frame,
  input  logic [15:0]        length_frames,
  input  logic [23:0]        step_ratio,
  input  logic [7:0]         sound_id,
  input  logic [15:0]        pitch_key,
  input  logic               is_instrument,
  input  logic               loop_enable,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] audio_sample,
  output logic               channel_index,
  output logic               is_audio,
  output logic [1:0]         status,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import pvm_pkg::*;

  localparam logic REG_NUM_CHANNELS = 1'b0;
  localparam logic REG_MASTER_GAIN  = 1'b1;

  logic [1:0]  num_channels;
  logic [15:0] master_gain;
  logic        cmd_avail;
  logic        cmd_pop;
  cmd_item_t   cmd_head;
  logic        res_push;
  logic        res_full;
  res_t        res;
  res_t        head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels <= 2'd2;
      master_gain  <= 16'd26214;
    end else if (cfg_valid) begin
      if (cfg_index == REG_NUM_CHANNELS) begin
        num_channels <= cfg_data[1:0];
      end else if (cfg_index == REG_MASTER_GAIN) begin
        master_gain <= cfg_data;
      end
    end
  end

  pvm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .sample_addr   (sample_addr),
    .sample_value  (sample_value),
    .start_frame   (start_frame),
    .length_frames (length_frames),
    .step_ratio    (step_ratio),
    .sound_id      (sound_id),
    .pitch_key     (pitch_key),
    .is_instrument (is_instrument),
    .loop_enable   (loop_enable),
    .avail         (cmd_avail),
    .pop           (cmd_pop),
    .head          (cmd_head)
  );

  pvm_engine #(
    .MAX_VOICES   (MAX_VOICES),
    .SAMPLE_WORDS (SAMPLE_WORDS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cmd_avail    (cmd_avail),
    .cmd_pop      (cmd_pop),
    .cmd_head     (cmd_head),
    .num_channels (num_channels),
    .master_gain  (master_gain),
    .res_push     (res_push),
    .res_full     (res_full),
    .res          (res)
  );

  pvm_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .head  (head)
  );

  assign audio_sample  = head.sample;
  assign channel_index = head.chan;
  assign is_audio      = head.audio;
  assign status        = head.status;
  assign last          = head.last;

endmodule
